// ----- hw/rtl/hob_pkg.sv -----
// hob_pkg: shared types and constants of the horizon occlusion buffer
// transaction structs, operation codes, datapath widths and walk control structs
// no dependencies
package hob_pkg;

	// field and datapath widths
	localparam int COORD_W = 24;
	localparam int CFG_W   = 11;
	localparam int SLOPE_W = 32;
	localparam int ACC_W   = 50;
	localparam int IX_W    = 17;
	localparam int XW      = 26;
	localparam int NUM_W   = 40;
	localparam int DEN_W   = 24;
	localparam int PROD_W  = 57;

	// operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_TEST   = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	// height limits and register reset
	localparam logic signed [COORD_W-1:0] HEIGHT_MIN = 24'sh800000;
	localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd1024;

	// input transaction
	typedef struct packed {
		logic [1:0]                operation;
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
	} hob_in_t;

	// result transaction
	typedef struct packed {
		logic hidden;
		logic was_test;
	} hob_out_t;

	// command to the column walker
	typedef struct packed {
		logic                      go;
		logic                      clear;
		logic                      is_test;
		logic signed [IX_W-1:0]    first_col;
		logic signed [IX_W-1:0]    last_col;
		logic signed [ACC_W-1:0]   y_start;
		logic signed [SLOPE_W-1:0] slope;
	} hob_walk_cmd_t;

	// status from the column walker
	typedef struct packed {
		logic busy;
		logic done;
		logic hidden;
	} hob_walk_sts_t;

endpackage

// ----- hw/rtl/hob_slope_div.sv -----
// hob_slope_div: radix-2 restoring divider for the segment slope
// one quotient bit per cycle, sign and 32-bit saturation at the end
// depends on hob_pkg
module hob_slope_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [hob_pkg::NUM_W-1:0]          num,
	input  logic [hob_pkg::DEN_W-1:0]          den,
	input  logic                               neg,
	output logic                               done,
	output logic signed [hob_pkg::SLOPE_W-1:0] slope
);
	import hob_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	typedef enum logic [1:0] {
		D_IDLE,
		D_RUN,
		D_SAT
	} div_state_t;

	div_state_t         state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DEN_W-1:0]   rem_q;
	logic [NUM_W-1:0]   quo_q;
	logic [DEN_W-1:0]   den_q;
	logic               neg_q;
	logic               done_q;
	logic signed [SLOPE_W-1:0] slope_q;

	logic [DEN_W:0]     trial;
	logic [DEN_W:0]     diff;
	logic               ge;
	logic [DEN_W-1:0]   rem_next;
	logic               over_pos;
	logic               over_neg;

	// one restoring step
	always_comb begin
		trial    = {rem_q, quo_q[NUM_W-1]};
		diff     = trial - {1'b0, den_q};
		ge       = (trial >= {1'b0, den_q});
		rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
	end

	// saturation limits on the magnitude
	always_comb begin
		over_pos = |quo_q[NUM_W-1:SLOPE_W-1];
		over_neg = (|quo_q[NUM_W-1:SLOPE_W]) ||
			(quo_q[SLOPE_W-1] && (|quo_q[SLOPE_W-2:0]));
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (start) begin
						rem_q   <= '0;
						quo_q   <= num;
						den_q   <= den;
						neg_q   <= neg;
						cnt_q   <= '0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					rem_q <= rem_next;
					quo_q <= {quo_q[NUM_W-2:0], ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(NUM_W - 1)) begin
						state_q <= D_SAT;
					end
				end
				D_SAT: begin
					if (neg_q) begin
						slope_q <= over_neg ? {1'b1, {(SLOPE_W-1){1'b0}}} :
							-$signed(quo_q[SLOPE_W-1:0]);
					end else begin
						slope_q <= over_pos ? {1'b0, {(SLOPE_W-1){1'b1}}} :
							$signed(quo_q[SLOPE_W-1:0]);
					end
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	assign done  = done_q;
	assign slope = slope_q;

	// start only lands on an idle divider
	assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (state_q == D_IDLE))
		else $error("divider started while busy");

	// the result follows the last quotient bit
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == D_SAT))
		else $error("divider done out of sequence");

	// remainder stays below the divisor while running
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == D_RUN) |-> (rem_q < den_q))
		else $error("divider remainder out of range");

endmodule

// ----- hw/rtl/hob_column_walk.sv -----
// hob_column_walk: column height memory with its clearing sweep and column walk
// reads one column per cycle, compares next cycle, writes back raised heights
// depends on hob_pkg
module hob_column_walk #(
	parameter int WIDTH = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hob_pkg::hob_walk_cmd_t cmd,
	output hob_pkg::hob_walk_sts_t sts
);
	import hob_pkg::*;

	localparam int AW = $clog2(WIDTH);

	typedef enum logic [1:0] {
		W_CLEAR,
		W_IDLE,
		W_RUN,
		W_DRAIN
	} walk_state_t;

	// column heights, read data registered
	logic signed [COORD_W-1:0] heights_q [WIDTH];
	logic signed [COORD_W-1:0] rd_data_q;

	walk_state_t               state_q;
	logic [AW-1:0]             clr_q;
	logic signed [IX_W-1:0]    col_q;
	logic signed [IX_W-1:0]    last_q;
	logic signed [ACC_W-1:0]   y_q;
	logic signed [SLOPE_W-1:0] slope_q;
	logic                      is_test_q;
	logic                      done_q;
	logic                      hidden_q;

	// compare stage
	logic                      valid_s1;
	logic [AW-1:0]             addr_s1;
	logic signed [ACC_W-1:0]   y_s1;

	logic                      rd_en;
	logic [AW-1:0]             rd_addr;
	logic                      wr_en;
	logic [AW-1:0]             wr_addr;
	logic signed [COORD_W-1:0] wr_data;
	logic                      above;
	logic                      fail_now;
	logic                      sat_hi;
	logic signed [COORD_W-1:0] line_h;

	// line against stored height, stored value of the line
	always_comb begin
		above    = y_s1 > $signed({{(ACC_W-COORD_W-8){rd_data_q[COORD_W-1]}}, rd_data_q, 8'h00});
		fail_now = valid_s1 && is_test_q && above;
		sat_hi   = !y_s1[ACC_W-1] && (|y_s1[ACC_W-2:COORD_W+7]);
		line_h   = sat_hi ? {1'b0, {(COORD_W-1){1'b1}}} : y_s1[COORD_W+7:8];
	end

	// memory port control
	always_comb begin
		rd_en   = (state_q == W_RUN);
		rd_addr = col_q[AW-1:0];
		wr_en   = (state_q == W_CLEAR) || (valid_s1 && !is_test_q && above);
		wr_addr = (state_q == W_CLEAR) ? clr_q : addr_s1;
		wr_data = (state_q == W_CLEAR) ? HEIGHT_MIN : line_h;
	end

	// height memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			heights_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= heights_q[rd_addr];
		end
	end

	// issue pointer to compare stage
	always_ff @(posedge clk) begin
		addr_s1 <= col_q[AW-1:0];
		y_s1    <= y_q;
	end

	// sweep and walk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= W_CLEAR;
			clr_q    <= '0;
			done_q   <= 1'b0;
			hidden_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			valid_s1 <= (state_q == W_RUN) && !fail_now;
			case (state_q)
				W_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(WIDTH - 1)) begin
						done_q   <= 1'b1;
						hidden_q <= 1'b0;
						state_q  <= W_IDLE;
					end
				end
				W_IDLE: begin
					if (cmd.go) begin
						if (cmd.clear) begin
							clr_q   <= '0;
							state_q <= W_CLEAR;
						end else begin
							col_q     <= cmd.first_col;
							last_q    <= cmd.last_col;
							y_q       <= cmd.y_start;
							slope_q   <= cmd.slope;
							is_test_q <= cmd.is_test;
							state_q   <= W_RUN;
						end
					end
				end
				W_RUN: begin
					col_q <= col_q + 1'b1;
					y_q   <= y_q + {{(ACC_W-SLOPE_W){slope_q[SLOPE_W-1]}}, slope_q};
					if (fail_now) begin
						done_q   <= 1'b1;
						hidden_q <= 1'b0;
						state_q  <= W_IDLE;
					end else if (col_q == last_q) begin
						state_q <= W_DRAIN;
					end
				end
				W_DRAIN: begin
					if (fail_now) begin
						done_q   <= 1'b1;
						hidden_q <= 1'b0;
						state_q  <= W_IDLE;
					end else if (!valid_s1) begin
						done_q   <= 1'b1;
						hidden_q <= is_test_q;
						state_q  <= W_IDLE;
					end
				end
				default: begin
					state_q <= W_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		sts.busy   = (state_q != W_IDLE);
		sts.done   = done_q;
		sts.hidden = hidden_q;
	end

	// a read never meets a write to the same column
	assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("read and write collide on one column");

	// a test walk never touches the memory contents
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && is_test_q) |-> !wr_en)
		else $error("write during test walk");

	// commands only arrive while the walker is idle
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.go |-> (state_q == W_IDLE))
		else $error("walk command while busy");

	// completion is a single pulse
	assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |=> !sts.done)
		else $error("walk done held longer than one cycle");

endmodule

// ----- hw/rtl/horizon_occlusion_buffer.sv -----
// horizon_occlusion_buffer: top level, item sequencing, endpoint clipping and result register
// insert/test: N columns walked, one read per column; the 40-step slope divider is skipped when dx is 0,
// the walk is skipped when it is empty, and a test that fails ends it early
// clear: one memory write per column; one item in flight
// after reset a clearing pass over every column keeps item_stall high
module horizon_occlusion_buffer #(
	parameter int WIDTH = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  hob_pkg::hob_in_t                item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output hob_pkg::hob_out_t               result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [hob_pkg::CFG_W-1:0]       cfg_data
);
	import hob_pkg::*;

	localparam int CLW = ($clog2(WIDTH + 1) > CFG_W) ? $clog2(WIDTH + 1) : CFG_W;

	typedef enum logic [2:0] {
		T_INIT,
		T_IDLE,
		T_CHECK,
		T_DIV,
		T_MUL,
		T_SETUP,
		T_WALK,
		T_OUT
	} top_state_t;

	top_state_t                state_q;
	logic [CFG_W-1:0]          active_width_q;
	logic [1:0]                op_q;
	logic signed [COORD_W-1:0] x1_q;
	logic signed [COORD_W-1:0] y1_q;
	logic signed [COORD_W-1:0] x2_q;
	logic signed [COORD_W-1:0] y2_q;
	logic signed [SLOPE_W-1:0] slope_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [IX_W-1:0]    ix1_q;
	logic signed [IX_W-1:0]    ix2_q;
	logic                      div_start_q;
	hob_walk_cmd_t             cmd_q;
	hob_out_t                  res_q;
	hob_out_t                  result_q;
	logic                      result_valid_q;

	logic                      swap;
	logic                      is_test;
	logic [CLW-1:0]            aw_ext;
	logic [CLW-1:0]            w_clamp;
	logic [CLW-1:0]            w_m1;
	logic signed [XW-1:0]      right;
	logic signed [XW-1:0]      x1e;
	logic signed [XW-1:0]      x2e;
	logic                      off_screen;
	logic signed [COORD_W:0]   dx_w;
	logic signed [COORD_W:0]   dy_w;
	logic signed [COORD_W:0]   dy_neg;
	logic [DEN_W-1:0]          dy_mag;
	logic [COORD_W-1:0]        negx;
	logic signed [PROD_W-1:0]  mul_w;
	logic [COORD_W-1:0]        x1c;
	logic [COORD_W:0]          ix1_sum;
	logic signed [XW-1:0]      x2c;
	logic signed [XW-1:0]      ix2_d;
	logic signed [ACC_W-1:0]   y_start;
	logic                      div_done;
	logic signed [SLOPE_W-1:0] div_slope;
	hob_walk_sts_t             sts;

	// visible column count clamped to the buffer
	always_comb begin
		aw_ext = CLW'(active_width_q);
		if (aw_ext < CLW'(2)) begin
			w_clamp = CLW'(2);
		end else if (aw_ext > CLW'(WIDTH)) begin
			w_clamp = CLW'(WIDTH);
		end else begin
			w_clamp = aw_ext;
		end
		w_m1  = w_clamp - 1'b1;
		right = $signed(XW'({w_m1, 8'h00}));
	end

	// endpoint order and off-screen check
	always_comb begin
		swap       = $signed(item.start_x) > $signed(item.end_x);
		is_test    = (op_q == OP_TEST);
		x1e        = {{(XW-COORD_W){x1_q[COORD_W-1]}}, x1_q};
		x2e        = {{(XW-COORD_W){x2_q[COORD_W-1]}}, x2_q};
		off_screen = x2_q[COORD_W-1] || (is_test ? (x1e > right) : (x1e >= right));
	end

	// divider operands
	always_comb begin
		dx_w   = {x2_q[COORD_W-1], x2_q} - {x1_q[COORD_W-1], x1_q};
		dy_w   = {y2_q[COORD_W-1], y2_q} - {y1_q[COORD_W-1], y1_q};
		dy_neg = -dy_w;
		dy_mag = dy_w[COORD_W] ? dy_neg[DEN_W-1:0] : dy_w[DEN_W-1:0];
	end

	// left clip correction and walked column range
	always_comb begin
		negx    = -x1_q;
		mul_w   = $signed(PROD_W'({1'b0, negx})) * PROD_W'(slope_q);
		x1c     = x1_q[COORD_W-1] ? '0 : x1_q;
		ix1_sum = {1'b0, x1c} + (COORD_W+1)'(127);
		x2c     = (x2e > right) ? right : x2e;
		ix2_d   = x2c - XW'(128);
		y_start = $signed({{(ACC_W-COORD_W-8){y1_q[COORD_W-1]}}, y1_q, 8'h00}) +
			$signed({{(ACC_W-PROD_W+8){prod_q[PROD_W-1]}}, prod_q[PROD_W-1:8]});
	end

	hob_slope_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    ({dy_mag, 16'h0000}),
		.den    (dx_w[DEN_W-1:0]),
		.neg    (dy_w[COORD_W]),
		.done   (div_done),
		.slope  (div_slope)
	);

	hob_column_walk #(
		.WIDTH (WIDTH)
	) u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_q),
		.sts    (sts)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_width_q <= WIDTH_RESET;
		end else if (cfg_valid) begin
			active_width_q <= cfg_data;
		end
	end

	// item sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= T_INIT;
			div_start_q    <= 1'b0;
			cmd_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			cmd_q.go    <= 1'b0;
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				T_INIT: begin
					if (!sts.busy) begin
						state_q <= T_IDLE;
					end
				end
				T_IDLE: begin
					if (item_valid) begin
						op_q <= item.operation;
						x1_q <= swap ? item.end_x : item.start_x;
						y1_q <= swap ? item.end_y : item.start_y;
						x2_q <= swap ? item.start_x : item.end_x;
						y2_q <= swap ? item.start_y : item.end_y;
						res_q.hidden   <= 1'b0;
						res_q.was_test <= (item.operation == OP_TEST);
						case (item.operation)
							OP_CLEAR: begin
								cmd_q.go    <= 1'b1;
								cmd_q.clear <= 1'b1;
								state_q     <= T_WALK;
							end
							OP_NONE: begin
								state_q <= T_OUT;
							end
							default: begin
								state_q <= T_CHECK;
							end
						endcase
					end
				end
				T_CHECK: begin
					if (off_screen) begin
						state_q <= T_OUT;
					end else if (dx_w == '0) begin
						slope_q <= '0;
						state_q <= T_MUL;
					end else begin
						div_start_q <= 1'b1;
						state_q     <= T_DIV;
					end
				end
				T_DIV: begin
					if (div_done) begin
						slope_q <= div_slope;
						state_q <= T_MUL;
					end
				end
				T_MUL: begin
					prod_q  <= x1_q[COORD_W-1] ? mul_w : '0;
					ix1_q   <= $signed(ix1_sum[COORD_W:8]);
					ix2_q   <= $signed(ix2_d[IX_W+7:8]);
					state_q <= T_SETUP;
				end
				T_SETUP: begin
					if (ix2_q < ix1_q) begin
						res_q.hidden <= is_test;
						state_q      <= T_OUT;
					end else begin
						cmd_q.go        <= 1'b1;
						cmd_q.clear     <= 1'b0;
						cmd_q.is_test   <= is_test;
						cmd_q.first_col <= ix1_q;
						cmd_q.last_col  <= ix2_q;
						cmd_q.y_start   <= y_start;
						cmd_q.slope     <= slope_q;
						state_q         <= T_WALK;
					end
				end
				T_WALK: begin
					if (sts.done) begin
						res_q.hidden <= sts.hidden;
						state_q      <= T_OUT;
					end
				end
				T_OUT: begin
					if (!result_valid_q || !result_stall) begin
						result_q       <= res_q;
						result_valid_q <= 1'b1;
						state_q        <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign item_stall   = (state_q != T_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// walk results only arrive while waiting for them
	assert property (@(posedge clk) disable iff (!arst_n)
		(sts.done && (state_q != T_INIT)) |-> (state_q == T_WALK))
		else $error("walk done outside walk wait");

	// a result is loaded only into a free or draining output register
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == T_OUT) && result_valid_q && result_stall) |=> (state_q == T_OUT))
		else $error("result overwrote a waiting result");

	// an insert never reports hidden
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (!result_q.hidden || result_q.was_test))
		else $error("hidden set on a non-test result");

endmodule
